FILE: rtl/core/b64d_pkg.sv
// shared types, constants and the character map of the base64 decoder
package b64d_pkg;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;  // '='
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
    localparam logic [7:0] CHAR_D0    = 8'h30;
    localparam logic [7:0] CHAR_D9    = 8'h39;

    localparam int unsigned GROUP_BITS = 24;
    localparam int unsigned STORE_BITS = 18;

    // one finished group handed to the output buffer
    typedef struct packed {
        logic                  load;
        logic [GROUP_BITS-1:0] word;
        logic [1:0]            count;
        logic                  last;
    } t_group;

    // standard alphabet, everything else maps to zero
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            t = c - CHAR_UP_A;
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            t = c - CHAR_LO_A + 8'd26;
        end else if (c >= CHAR_D0 && c <= CHAR_D9) begin
            t = c - CHAR_D0 + 8'd52;
        end else if (c == CHAR_PLUS) begin
            t = 8'd62;
        end else if (c == CHAR_SLASH) begin
            t = 8'd63;
        end
        return t[5:0];
    endfunction

endpackage

FILE: rtl/core/base64_stream_decoder.sv
// top level of the base64 stream decoder
// base64 decoder, one character per beat in, one byte per beat out. a
// character that does not close a group is always accepted in the cycle it
// arrives. a closing character (the fourth of a group, or one with tlast) is
// held off while more than one byte of the previous group is still pending,
// or while one is pending and the sink is not ready. the first byte of a group
// is offered in the cycle after its closing character, then one byte per cycle
// while the sink is ready. with a full-rate sink, groups of four run at one
// character per clock. a group that closes one or two characters after a
// three-byte group, or one character after a two-byte group, stalls,
// even when it gives no bytes. '=' counts as a pad anywhere in a group and
// each pad drops one byte; a stream ending on k characters gives k-1 bytes
// minus pads, and tlast on the output marks the last byte of the final group
// of a stream, if it gives any. characters outside the alphabet decode as zero.
module base64_stream_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,   // end_of_text
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tlast    // final_byte
);

    // open group: earlier sextets, their count, pads seen so far
    logic [b64d_pkg::STORE_BITS-1:0] r_store, n_store;
    logic [1:0]                      r_gcnt, n_gcnt;
    logic [1:0]                      r_pads, n_pads;

    logic             closes;      // this character ends the group
    logic             buf_free;
    logic             accept;
    logic [5:0]       sextet;
    logic [1:0]       pads;
    logic [2:0]       chars;       // characters in the group, 1..4
    logic [2:0]       real_chars;
    logic [b64d_pkg::GROUP_BITS-1:0] word;
    b64d_pkg::t_group grp;

    assign closes        = (r_gcnt == 2'd3) || s_axis_tlast;
    assign s_axis_tready = !closes || buf_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign sextet        = b64d_pkg::sextet_of(s_axis_tdata);
    assign chars         = {1'b0, r_gcnt} + 3'd1;

    // pad count saturates at three
    always_comb begin
        pads = r_pads;
        if ((s_axis_tdata == b64d_pkg::CHAR_PAD) && (r_pads != 2'd3)) begin
            pads = r_pads + 2'd1;
        end
    end

    // left-aligned group word, missing sextets are zero
    always_comb begin
        unique case (r_gcnt)
            2'd0:    word = {sextet, 18'd0};
            2'd1:    word = {r_store[5:0], sextet, 12'd0};
            2'd2:    word = {r_store[11:0], sextet, 6'd0};
            default: word = {r_store, sextet};
        endcase
    end

    // bytes out = characters - pads - 1, floored at zero
    always_comb begin
        real_chars = (chars > {1'b0, pads}) ? (chars - {1'b0, pads}) : 3'd0;
        grp.load   = accept && closes;
        grp.word   = word;
        grp.count  = (real_chars != 3'd0) ? 2'(real_chars - 3'd1) : 2'd0;
        grp.last   = s_axis_tlast;
    end

    // group state: shift in, or clear on close
    always_comb begin
        n_store = r_store;
        n_gcnt  = r_gcnt;
        n_pads  = r_pads;
        if (accept) begin
            if (closes) begin
                n_store = '0;
                n_gcnt  = 2'd0;
                n_pads  = 2'd0;
            end else begin
                n_store = {r_store[b64d_pkg::STORE_BITS-7:0], sextet};
                n_gcnt  = r_gcnt + 2'd1;
                n_pads  = pads;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_gcnt  <= 2'd0;
            r_pads  <= 2'd0;
        end else begin
            r_store <= n_store;
            r_gcnt  <= n_gcnt;
            r_pads  <= n_pads;
        end
    end

    b64d_byte_buffer u_buffer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_group       (grp),
        .o_free        (buf_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

FILE: rtl/core/b64d_byte_buffer.sv
// output buffer that drains one decoded group a byte per beat
module b64d_byte_buffer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  b64d_pkg::t_group      i_group,
    output logic                  o_free,        // a group may be loaded this cycle
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,  // [7:0] data_byte
    output logic                  m_axis_tlast   // final_byte
);

    logic [b64d_pkg::GROUP_BITS-1:0] r_word, n_word;
    logic [1:0]                      r_cnt, n_cnt;
    logic                            r_last, n_last;
    logic                            beat;

    assign beat          = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_word[b64d_pkg::GROUP_BITS-1 -: 8];
    assign m_axis_tlast  = r_last && (r_cnt == 2'd1);
    // empty, or the last pending byte leaves now
    assign o_free        = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && m_axis_tready);

    always_comb begin
        n_word = r_word;
        n_cnt  = r_cnt;
        n_last = r_last;
        if (i_group.load) begin
            n_word = i_group.word;
            n_cnt  = i_group.count;
            n_last = i_group.last;
        end else if (beat) begin
            n_word = {r_word[b64d_pkg::GROUP_BITS-9:0], 8'd0};
            n_cnt  = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_last <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_last <= n_last;
        end
        r_word <= n_word;
    end

endmodule
